/* src/abfc_pkg.sv */
package abfc_pkg;

    localparam int BLOCKS     = 4;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 3;
    localparam int BLK_IDX_W  = $clog2(BLOCKS);
    localparam int CAL_IDX_W  = $clog2(BLOCKS + 1);
    localparam int PED_W      = 48;
    localparam int DIV_CNT_W  = $clog2(PED_W);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int PADDR_W    = 4;

    localparam logic [POS_W-1:0] POS_TOTAL  = POS_W'(BLOCKS);
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(BLOCKS + 1);

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_PEDESTAL  = 2'd1;
    localparam logic [1:0] REG_CALFACTOR = 2'd2;
    localparam logic [1:0] REG_BLOCKS    = 2'd3;

    typedef struct packed {
        logic [31:0] data_word;
        logic        last_in_buffer;
    } abfc_in_t;

    typedef struct packed {
        logic [63:0] block0_value;
        logic [63:0] block1_value;
        logic [63:0] block2_value;
        logic [63:0] block3_value;
        logic [63:0] total_value;
        logic [7:0]  seq_id;
        logic [15:0] sample_count;
        logic        sums_match;
        logic        short_frame;
    } abfc_out_t;

    typedef struct packed {
        logic [BLOCKS-1:0][WORD_W-1:0] raw;
        logic [WORD_W-1:0]             hw_total;
        logic [7:0]                    seq;
        logic [15:0]                   ns;
        logic                          sums_match;
        logic                          short_frame;
    } abfc_job_t;

    typedef struct packed {
        logic        channel_enabled;
        logic [31:0] pedestal;
        logic [31:0] calibration_factor;
        logic [4:0]  blocks_per_event;
    } abfc_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } abfc_qstat_t;

endpackage

/* src/abfc_front.sv */
module abfc_front
    import abfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  abfc_in_t    item,
    output logic        full,
    input  logic        enabled,
    input  abfc_qstat_t qstat,
    output logic        job_push,
    output abfc_job_t   job
);

    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [WORD_W+1:0]             block_total_reg, block_total_next;
    logic [BLOCKS-1:0][WORD_W-1:0] raw_reg;
    logic [WORD_W-1:0]             hw_reg;
    logic                          accept;
    logic                          is_status;

    assign full      = qstat.full;
    assign accept    = push & ~qstat.full;
    assign is_status = (pos_reg == POS_STATUS);

    always_comb
    begin
        block_total_next = block_total_reg;
        if (pos_reg < POS_TOTAL)
        begin
            block_total_next = ((pos_reg == '0) ? '0 : block_total_reg)
                               + {2'b00, item.data_word};
        end
        if (is_status || item.last_in_buffer)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        job_push = accept & enabled & (is_status | item.last_in_buffer);
        job = '0;
        if (is_status)
        begin
            job.raw        = raw_reg;
            job.hw_total   = hw_reg;
            job.seq        = item.data_word[15:8];
            job.ns         = item.data_word[31:16];
            job.sums_match = (block_total_reg == {2'b00, hw_reg});
        end
        else
        begin
            job.short_frame = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            block_total_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg         <= pos_next;
            block_total_reg <= block_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg < POS_TOTAL)
        begin
            raw_reg[pos_reg[BLK_IDX_W-1:0]] <= item.data_word;
        end
        if (accept && pos_reg == POS_TOTAL)
        begin
            hw_reg <= item.data_word;
        end
    end

endmodule

/* src/abfc_queue.sv */
module abfc_queue
    import abfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  abfc_job_t   wr_data,
    input  logic        rd_en,
    output abfc_job_t   rd_data,
    output abfc_qstat_t stat
);

    abfc_job_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;

    assign stat.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + (Q_PTR_W+1)'(wr_en) - (Q_PTR_W+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/abfc_back.sv */
module abfc_back
    import abfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  abfc_cfg_t   cfg,
    input  logic        job_valid,
    input  abfc_job_t   job,
    output logic        job_pop,
    output abfc_out_t   result,
    output logic        empty,
    input  logic        pop
);

    typedef enum logic [3:0] {
        S_IDLE, S_PMUL, S_DINIT, S_DIV, S_DEND,
        S_DSUB, S_MHI, S_MLO, S_FIN, S_OUT
    } state_t;

    state_t                      state_reg;
    abfc_job_t                   job_reg;
    logic signed [PED_W-1:0]     ped_all_reg, ped_blk_reg;
    logic [PED_W-1:0]            num_reg;
    logic [4:0]                  rem_reg;
    logic                        div_neg_reg;
    logic [DIV_CNT_W-1:0]        cnt_reg;
    logic [CAL_IDX_W-1:0]        idx_reg;
    logic [48:0]                 dm_reg;
    logic                        neg_reg;
    logic [48:0]                 hi_reg;
    logic [63:0]                 lo_reg;
    logic [BLOCKS:0][63:0]       vals_reg;
    abfc_out_t                   result_reg;
    logic                        res_valid_reg;

    logic signed [48:0]          ped_prod;
    logic [4:0]                  dv;
    logic [5:0]                  rem_sh;
    logic                        q_bit;
    logic [4:0]                  rem_next;
    logic [WORD_W-1:0]           raw_sel;
    logic [PED_W-1:0]            ped_sel;
    logic [49:0]                 d_val;
    logic [49:0]                 d_mag;
    logic [31:0]                 gm;
    logic [63:0]                 mag;
    logic [63:0]                 cal_val;
    logic                        out_free;
    abfc_out_t                   res_next;

    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign result  = result_reg;
    assign empty   = ~res_valid_reg;
    assign out_free = ~res_valid_reg | pop;

    always_comb
    begin
        ped_prod = 49'($signed(cfg.pedestal)) * 49'($signed({1'b0, job_reg.ns}));
        dv       = (cfg.blocks_per_event == '0) ? 5'd1 : cfg.blocks_per_event;

        // one restoring division step per cycle
        rem_sh   = {rem_reg, num_reg[PED_W-1]};
        q_bit    = (rem_sh >= {1'b0, dv});
        rem_next = q_bit ? 5'(rem_sh - {1'b0, dv}) : rem_sh[4:0];

        if (idx_reg == CAL_IDX_W'(BLOCKS))
        begin
            raw_sel = job_reg.hw_total;
            ped_sel = ped_all_reg;
        end
        else
        begin
            raw_sel = job_reg.raw[idx_reg[BLK_IDX_W-1:0]];
            ped_sel = ped_blk_reg;
        end
        d_val = {2'b00, raw_sel, 16'h0000} - {{2{ped_sel[PED_W-1]}}, ped_sel};
        d_mag = d_val[49] ? -d_val : d_val;
        gm    = cfg.calibration_factor[31] ? -cfg.calibration_factor
                                           : cfg.calibration_factor;

        if (hi_reg >= 49'(64'h0000_8000_0000_0000))
        begin
            mag = 64'h8000_0000_0000_0000;
        end
        else
        begin
            mag = {1'b0, hi_reg[46:0], 16'h0000} + {16'h0000, lo_reg[63:16]};
        end
        if (neg_reg)
        begin
            cal_val = mag[63] ? 64'h8000_0000_0000_0000 : -mag;
        end
        else
        begin
            cal_val = mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
        end

        res_next                 = '0;
        res_next.block0_value    = vals_reg[0];
        res_next.block1_value    = vals_reg[1];
        res_next.block2_value    = vals_reg[2];
        res_next.block3_value    = vals_reg[3];
        res_next.total_value     = vals_reg[BLOCKS];
        res_next.seq_id          = job_reg.seq;
        res_next.sample_count    = job_reg.ns;
        res_next.sums_match      = job_reg.sums_match;
        res_next.short_frame     = job_reg.short_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            ped_all_reg   <= '0;
            ped_blk_reg   <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            div_neg_reg   <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            dm_reg        <= '0;
            neg_reg       <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            vals_reg      <= '0;
            result_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_OUT a pop hands over directly to the next request
            if (pop && state_reg != S_OUT)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        if (job.short_frame)
                        begin
                            vals_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PMUL;
                        end
                    end
                end
                S_PMUL:
                begin
                    ped_all_reg <= ped_prod[PED_W-1:0];
                    state_reg   <= S_DINIT;
                end
                S_DINIT:
                begin
                    div_neg_reg <= ped_all_reg[PED_W-1];
                    num_reg     <= ped_all_reg[PED_W-1] ? -ped_all_reg : ped_all_reg;
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[PED_W-2:0], q_bit};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(PED_W - 1))
                    begin
                        state_reg <= S_DEND;
                    end
                end
                S_DEND:
                begin
                    // quotient truncates toward zero
                    ped_blk_reg <= div_neg_reg ? -num_reg : num_reg;
                    idx_reg     <= '0;
                    state_reg   <= S_DSUB;
                end
                S_DSUB:
                begin
                    dm_reg    <= d_mag[48:0];
                    neg_reg   <= d_val[49] ^ cfg.calibration_factor[31];
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    hi_reg    <= {32'd0, dm_reg[48:32]} * {17'd0, gm};
                    state_reg <= S_MLO;
                end
                S_MLO:
                begin
                    lo_reg    <= {32'd0, dm_reg[31:0]} * {32'd0, gm} + 64'd32768;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    vals_reg[idx_reg] <= cal_val;
                    if (idx_reg == CAL_IDX_W'(BLOCKS))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CAL_IDX_W'(1);
                        state_reg <= S_DSUB;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg    <= res_next;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/adc_block_frame_calibrator.sv */
// ADC block frame calibrator.
// Input queue port (push/full/item): readout words, frames of four block sums,
// a hardware total and a status word; a word is taken when push is high and
// full is low. Result queue port (empty/pop/result): one calibrated Q48.16
// request per frame while the channel is enabled, held until popped.
// APB port: 0x0 channel enable, 0x4 pedestal, 0x8 gain, 0xC blocks per event.
// Words enter at one per cycle while the job queue (two frames) has room.
// A full frame is processed after its status word by a pedestal multiply, a
// bit-serial divide of the pedestal by blocks per event, then per value a
// subtract, two partial products, and a round and saturate step, for five
// values. A short-frame request skips this and carries zero values. The
// back-end sequencer finishes one frame before it takes the next. When pop
// stays low the finished request holds, the back end waits, the job queue
// fills and full rises. Reset clears the frame position, the queues and the
// result, and loads enable 1, pedestal 0, gain 1.0 and blocks per event 4.
module adc_block_frame_calibrator
    import abfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  abfc_in_t           item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output abfc_out_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    abfc_cfg_t   cfg_reg;
    logic        cfg_wr;
    logic        job_push;
    abfc_job_t   job_in;
    abfc_job_t   job_out;
    logic        job_pop;
    abfc_qstat_t qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_enabled    <= 1'b1;
            cfg_reg.pedestal           <= '0;
            cfg_reg.calibration_factor <= 32'd65536;
            cfg_reg.blocks_per_event   <= 5'd4;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ENABLE:    cfg_reg.channel_enabled    <= pwdata[0];
                REG_PEDESTAL:  cfg_reg.pedestal           <= pwdata;
                REG_CALFACTOR: cfg_reg.calibration_factor <= pwdata;
                REG_BLOCKS:    cfg_reg.blocks_per_event   <= pwdata[4:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE:    prdata = {31'd0, cfg_reg.channel_enabled};
            REG_PEDESTAL:  prdata = cfg_reg.pedestal;
            REG_CALFACTOR: prdata = cfg_reg.calibration_factor;
            REG_BLOCKS:    prdata = {27'd0, cfg_reg.blocks_per_event};
            default:       prdata = '0;
        endcase
    end

    abfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .enabled  (cfg_reg.channel_enabled),
        .qstat    (qstat),
        .job_push (job_push),
        .job      (job_in)
    );

    abfc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .stat    (qstat)
    );

    abfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (~qstat.empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
